[rtl/fbal_pkg.sv]
package fbal_pkg;

  localparam logic [31:0] SIG_FAT     = 32'hCAFE_BABE;
  localparam logic [31:0] SIG_FAT_INV = 32'hBEBA_FECA;
  localparam logic [31:0] SIG_EFI_FAT = 32'h0EF1_FAB9;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WANTED_CPU   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  localparam int unsigned OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    PH_SIG,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] swapped;
    logic        sig_fat;
    logic        sig_inv;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [31:0] buffer_bytes;
    logic [31:0] image_bytes;
    logic [31:0] wanted_cpu;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] slice_offset;
    logic [31:0] slice_size;
  } res_t;

endpackage

[rtl/fbal_front.sv]
module fbal_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,
  input  logic                in_tlast,
  output logic                q_valid,
  input  logic                q_ready,
  output fbal_pkg::item_t     q_item
);

  logic            valid_r;
  fbal_pkg::item_t item_r;
  fbal_pkg::item_t item_nxt;

  assign in_tready = !valid_r || q_ready;
  assign q_valid   = valid_r;
  assign q_item    = item_r;

  always_comb begin
    item_nxt.raw     = in_tdata;
    item_nxt.swapped = {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16], in_tdata[31:24]};
    item_nxt.sig_inv = (in_tdata == fbal_pkg::SIG_FAT_INV);
    item_nxt.sig_fat = (in_tdata == fbal_pkg::SIG_FAT) || (in_tdata == fbal_pkg::SIG_FAT_INV) ||
                       (in_tdata == fbal_pkg::SIG_EFI_FAT);
    item_nxt.last    = in_tlast;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/fbal_queue.sv]
module fbal_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fbal_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fbal_pkg::item_t pop_item
);

  fbal_pkg::item_t                   mem_r [fbal_pkg::QUEUE_DEPTH];
  logic [fbal_pkg::QUEUE_AW-1:0]     wr_ptr_r;
  logic [fbal_pkg::QUEUE_AW-1:0]     rd_ptr_r;
  logic [fbal_pkg::QUEUE_AW:0]       count_r;
  logic                              push;
  logic                              pop;

  assign push_ready = (count_r != (fbal_pkg::QUEUE_AW + 1)'(fbal_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/fbal_back.sv]
module fbal_back #(
  parameter int unsigned ENTRY_WORDS = 5
) (
  input  logic            clk,
  input  logic            rst_n,
  input  fbal_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_ready,
  input  fbal_pkg::item_t q_item,
  output logic            res_valid,
  input  logic            res_ready,
  output fbal_pkg::res_t  res
);

  localparam int unsigned ENTRY_BYTES = ENTRY_WORDS * 4;
  localparam int unsigned NEED_W      = 32 + $clog2(ENTRY_BYTES) + 1;
  localparam int unsigned FP_W        = $clog2(ENTRY_WORDS);
  localparam logic [FP_W-1:0] FP_CPU    = FP_W'(0);
  localparam logic [FP_W-1:0] FP_OFFSET = FP_W'(2);
  localparam logic [FP_W-1:0] FP_SIZE   = FP_W'(3);
  localparam logic [FP_W-1:0] FP_END    = FP_W'(ENTRY_WORDS - 1);

  fbal_pkg::phase_t phase_r, phase_nxt;
  logic             swap_r, swap_nxt;
  logic [31:0]      entries_r, entries_nxt;
  logic [FP_W-1:0]  fpos_r, fpos_nxt;
  logic             matched_r, matched_nxt;
  logic [31:0]      held_r, held_nxt;
  logic             res_valid_r;
  fbal_pkg::res_t   res_r;

  logic             take;
  logic [31:0]      v;
  logic [NEED_W-1:0] need;
  logic [32:0]      slice_end;
  logic             emit;
  fbal_pkg::res_t   emit_res;

  assign take      = q_valid && (!res_valid_r || res_ready);
  assign q_ready   = take;
  assign res_valid = res_valid_r;
  assign res       = res_r;
  assign v         = swap_r ? q_item.swapped : q_item.raw;
  assign need      = NEED_W'(v) * NEED_W'(ENTRY_BYTES) + NEED_W'(8);
  assign slice_end = {1'b0, held_r} + {1'b0, v};

  always_comb begin
    emit     = 1'b0;
    emit_res = '{status: fbal_pkg::ST_INVALID, slice_offset: 32'd0, slice_size: 32'd0};
    unique case (phase_r)
      fbal_pkg::PH_SIG: begin
        if (cfg.buffer_bytes < 32'd8) begin
          emit = 1'b1;
        end else if (!q_item.sig_fat) begin
          emit = 1'b1;
          emit_res.status     = fbal_pkg::ST_OK;
          emit_res.slice_size = cfg.image_bytes;
        end
      end
      fbal_pkg::PH_COUNT: begin
        if ((|need[NEED_W-1:32]) || (need[31:0] > cfg.buffer_bytes)) begin
          emit = 1'b1;
        end else if (v == 32'd0) begin
          emit = 1'b1;
          emit_res.status = fbal_pkg::ST_NOTFOUND;
        end
      end
      fbal_pkg::PH_ENTRY: begin
        if (fpos_r == FP_SIZE && matched_r) begin
          emit = 1'b1;
          if (held_r != 32'd0 && !slice_end[32] && slice_end[31:0] <= cfg.image_bytes) begin
            emit_res.status       = fbal_pkg::ST_OK;
            emit_res.slice_offset = held_r;
            emit_res.slice_size   = v;
          end
        end else if (fpos_r == FP_END && entries_r == 32'd1) begin
          emit = 1'b1;
          emit_res.status = fbal_pkg::ST_NOTFOUND;
        end
      end
      fbal_pkg::PH_DONE: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
    if (q_item.last && phase_r != fbal_pkg::PH_DONE && !emit) begin
      emit = 1'b1;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    swap_nxt    = swap_r;
    entries_nxt = entries_r;
    fpos_nxt    = fpos_r;
    matched_nxt = matched_r;
    held_nxt    = held_r;
    if (take) begin
      if (q_item.last) begin
        phase_nxt   = fbal_pkg::PH_SIG;
        swap_nxt    = 1'b0;
        fpos_nxt    = '0;
        matched_nxt = 1'b0;
      end else if (emit) begin
        phase_nxt = fbal_pkg::PH_DONE;
      end else begin
        unique case (phase_r)
          fbal_pkg::PH_SIG: begin
            swap_nxt  = q_item.sig_inv;
            phase_nxt = fbal_pkg::PH_COUNT;
          end
          fbal_pkg::PH_COUNT: begin
            entries_nxt = v;
            fpos_nxt    = '0;
            matched_nxt = 1'b0;
            phase_nxt   = fbal_pkg::PH_ENTRY;
          end
          fbal_pkg::PH_ENTRY: begin
            if (fpos_r == FP_CPU) begin
              matched_nxt = (v == cfg.wanted_cpu);
            end else if (fpos_r == FP_OFFSET && matched_r) begin
              held_nxt = v;
            end
            if (fpos_r == FP_END) begin
              fpos_nxt    = '0;
              entries_nxt = entries_r - 32'd1;
            end else begin
              fpos_nxt = fpos_r + 1'b1;
            end
          end
          fbal_pkg::PH_DONE: begin
            phase_nxt = fbal_pkg::PH_DONE;
          end
          default: begin
            phase_nxt = fbal_pkg::PH_SIG;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= fbal_pkg::PH_SIG;
      swap_r      <= 1'b0;
      fpos_r      <= '0;
      matched_r   <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      swap_r    <= swap_nxt;
      fpos_r    <= fpos_nxt;
      matched_r <= matched_nxt;
      if (take && emit) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    entries_r <= entries_nxt;
    held_r    <= held_nxt;
    if (take && emit) begin
      res_r <= emit_res;
    end
  end

endmodule

[rtl/fat_binary_arch_locator_core.sv]
// Fat-binary slice locator. Header words enter one per clock on the in_ stream; each image
// (a run of words closed by tlast) yields exactly one registered result on the out_ stream; the
// deciding word goes via the front register and the queue. The block sustains one word per cycle:
// the front stage and a four-entry queue keep taking words while a result waits for out_tready,
// and input stalls only once that queue is full. Configuration registers are written through the
// cfg_ channel, which is always ready, and should only change while no image is in flight.
module fat_binary_arch_locator_core #(
  parameter int unsigned ENTRY_WORDS = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [31:0]                       in_tdata,   // word
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fbal_pkg::OUT_DATA_W-1:0]   out_tdata,  // status, slice_offset, slice_size
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fbal_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  fbal_pkg::cfg_t  cfg_r;
  fbal_pkg::item_t f_item;
  fbal_pkg::item_t q_item;
  fbal_pkg::res_t  res;
  logic            f_valid;
  logic            f_ready;
  logic            q_valid;
  logic            q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.buffer_bytes <= 32'd0;
      cfg_r.image_bytes  <= 32'd1;
      cfg_r.wanted_cpu   <= 32'd7;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fbal_pkg::REG_BUFFER_BYTES: cfg_r.buffer_bytes <= cfg_data;
        fbal_pkg::REG_IMAGE_BYTES:  cfg_r.image_bytes  <= cfg_data;
        fbal_pkg::REG_WANTED_CPU:   cfg_r.wanted_cpu   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fbal_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_item    (f_item)
  );

  fbal_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  fbal_back #(
    .ENTRY_WORDS (ENTRY_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {6'd0, res.slice_size, res.slice_offset, res.status};

endmodule

[tb/tb_fat_binary_arch_locator_core.sv]
`timescale 1ns / 100ps

module tb_fat_binary_arch_locator_core;

  localparam int unsigned ENTRY_WORDS = 5;
  localparam int unsigned WORD_TARGET = 850;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 400000;

  class slice_predictor;
    logic [31:0]       buffer_len;
    logic [31:0]       image_len;
    logic [31:0]       cpu_want;
    fbal_pkg::phase_t  ph;
    bit                swap_on;
    logic [31:0]       entries_left;
    int unsigned       field_pos;
    bit                cpu_hit;
    logic [31:0]       held_off;
    bit                answered;
    int unsigned       entry_words;
    fbal_pkg::res_t    answers_due[$];
    int unsigned       mismatches;

    function new(int unsigned ew);
      entry_words = ew;
      buffer_len = 32'd0;
      image_len = 32'd1;
      cpu_want = 32'd7;
      mismatches = 0;
      clear_image();
    endfunction

    static function logic [31:0] byte_flip(logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

    function void clear_image();
      ph = fbal_pkg::PH_SIG;
      swap_on = 1'b0;
      entries_left = 32'd0;
      field_pos = 0;
      cpu_hit = 1'b0;
      held_off = 32'd0;
      answered = 1'b0;
    endfunction

    function void set_reg(logic [fbal_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        fbal_pkg::REG_BUFFER_BYTES: buffer_len = val;
        fbal_pkg::REG_IMAGE_BYTES:  image_len = val;
        fbal_pkg::REG_WANTED_CPU:   cpu_want = val;
        default: ;
      endcase
    endfunction

    function void give(logic [1:0] st, logic [31:0] off, logic [31:0] sz);
      fbal_pkg::res_t r;
      r.status = st;
      r.slice_offset = off;
      r.slice_size = sz;
      answers_due.push_back(r);
      answered = 1'b1;
      ph = fbal_pkg::PH_DONE;
    endfunction

    function int unsigned pending();
      return answers_due.size();
    endfunction

    // Returns 1 when the word took part in the decision, 0 when it was skipped.
    function bit take_word(logic [31:0] w, logic is_last);
      logic [31:0] v;
      logic [63:0] need;
      logic [63:0] span_end;
      bit          used;
      bit          decided;
      used = !answered;
      decided = 1'b0;
      v = swap_on ? byte_flip(w) : w;
      if (!answered) begin
        case (ph)
          fbal_pkg::PH_SIG: begin
            if (buffer_len < 32'd8) begin
              give(fbal_pkg::ST_INVALID, 32'd0, 32'd0);
            end else if (w != fbal_pkg::SIG_FAT && w != fbal_pkg::SIG_FAT_INV &&
                         w != fbal_pkg::SIG_EFI_FAT) begin
              give(fbal_pkg::ST_OK, 32'd0, image_len);
            end else begin
              swap_on = (w == fbal_pkg::SIG_FAT_INV);
              ph = fbal_pkg::PH_COUNT;
            end
          end
          fbal_pkg::PH_COUNT: begin
            need = {32'd0, v} * (entry_words * 4) + 64'd8;
            if (need > 64'hFFFF_FFFF || need > {32'd0, buffer_len}) begin
              give(fbal_pkg::ST_INVALID, 32'd0, 32'd0);
            end else if (v == 32'd0) begin
              give(fbal_pkg::ST_NOTFOUND, 32'd0, 32'd0);
            end else begin
              entries_left = v;
              field_pos = 0;
              cpu_hit = 1'b0;
              ph = fbal_pkg::PH_ENTRY;
            end
          end
          fbal_pkg::PH_ENTRY: begin
            if (field_pos == 0) begin
              cpu_hit = (v == cpu_want);
            end else if (field_pos == 2 && cpu_hit) begin
              held_off = v;
            end else if (field_pos == 3 && cpu_hit) begin
              span_end = {32'd0, held_off} + {32'd0, v};
              if (held_off == 32'd0 || span_end > 64'hFFFF_FFFF ||
                  span_end > {32'd0, image_len}) begin
                give(fbal_pkg::ST_INVALID, 32'd0, 32'd0);
              end else begin
                give(fbal_pkg::ST_OK, held_off, v);
              end
              decided = 1'b1;
            end
            if (!decided) begin
              if (field_pos + 1 >= entry_words) begin
                field_pos = 0;
                entries_left = entries_left - 32'd1;
                if (entries_left == 32'd0) begin
                  give(fbal_pkg::ST_NOTFOUND, 32'd0, 32'd0);
                end
              end else begin
                field_pos = field_pos + 1;
              end
            end
          end
          default: ;
        endcase
      end
      if (is_last) begin
        if (!answered) begin
          give(fbal_pkg::ST_INVALID, 32'd0, 32'd0);
        end
        clear_image();
      end
      return used;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_answer(logic [fbal_pkg::OUT_DATA_W-1:0] d);
      fbal_pkg::res_t want;
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result, status", {30'd0, d[1:0]}, 32'd0);
      end else begin
        want = answers_due.pop_front();
        if (d[1:0] != want.status) begin
          report_mismatch("status", {30'd0, d[1:0]}, {30'd0, want.status});
        end
        if (d[33:2] != want.slice_offset) begin
          report_mismatch("slice_offset", d[33:2], want.slice_offset);
        end
        if (d[65:34] != want.slice_size) begin
          report_mismatch("slice_size", d[65:34], want.slice_size);
        end
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [31:0]                     in_tdata;
  logic                            in_tlast;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [fbal_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [fbal_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [31:0]                     cfg_data;

  slice_predictor sb;
  logic [32:0]    frame_q[$];
  logic [31:0]    cur_buffer;
  logic [31:0]    cur_image;
  logic [31:0]    cur_cpu;
  bit             steady;
  int unsigned    words_used;
  int unsigned    cycles = 0;

  fat_binary_arch_locator_core #(
    .ENTRY_WORDS(ENTRY_WORDS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_answer(out_tdata);
    end
  end

  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 4);
      if (gap != 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return fbal_pkg::SIG_FAT;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [31:0] w, logic is_last);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = w;
    in_tlast = is_last;
    do @(posedge clk); while (!in_tready);
    void'(sb.take_word(w, is_last));
    words_used++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_frame();
    frame_q[frame_q.size()-1][32] = 1'b1;
    foreach (frame_q[i]) begin
      send_word(frame_q[i][31:0], frame_q[i][32]);
    end
    frame_q = {};
  endtask

  task automatic push(logic [31:0] w, bit flip = 1'b0);
    frame_q.push_back({1'b0, flip ? slice_predictor::byte_flip(w) : w});
  endtask

  task automatic write_reg(logic [fbal_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    case (idx)
      fbal_pkg::REG_BUFFER_BYTES: cur_buffer = val;
      fbal_pkg::REG_IMAGE_BYTES:  cur_image = val;
      fbal_pkg::REG_WANTED_CPU:   cur_cpu = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic pick_span(output logic [31:0] off, output logic [31:0] sz);
    case ($urandom_range(0, 5))
      0: begin
        off = 32'd0;
        sz = $urandom_range(0, 255);
      end
      1: begin
        off = 32'hFFFF_FF00 | $urandom_range(0, 255);
        sz = 32'h100 + $urandom_range(0, 15);
      end
      2: begin
        off = $urandom_range(1, 16);
        sz = cur_image - off + 32'd1;
      end
      3: begin
        off = $urandom;
        sz = $urandom;
      end
      default: begin
        if (cur_image >= 32'd2) begin
          off = $urandom_range(1, cur_image - 1);
          sz = $urandom_range(0, cur_image - off);
        end else begin
          off = 32'd1;
          sz = 32'd0;
        end
      end
    endcase
  endtask

  task automatic build_fat_frame();
    logic [31:0] sig;
    logic [31:0] n;
    logic [31:0] cpu;
    logic [31:0] off;
    logic [31:0] sz;
    logic [31:0] maxn;
    bit          inv;
    int unsigned streamed;
    case ($urandom_range(0, 2))
      0: sig = fbal_pkg::SIG_FAT;
      1: sig = fbal_pkg::SIG_FAT_INV;
      default: sig = fbal_pkg::SIG_EFI_FAT;
    endcase
    inv = (sig == fbal_pkg::SIG_FAT_INV);
    maxn = (cur_buffer < 32'd8) ? 32'd0 : (cur_buffer - 32'd8) / 32'd20;
    if (maxn > 32'd4) maxn = 32'd4;
    case ($urandom_range(0, 11))
      0: n = maxn + 32'd1;
      1: n = 32'h0CCC_CCCD;
      2: n = $urandom;
      3: n = 32'd0;
      default: n = $urandom_range(1, (maxn > 0) ? maxn : 1);
    endcase
    push(sig);
    push(n, inv);
    streamed = (n > 32'd5) ? 5 : n;
    for (int unsigned e = 0; e < streamed; e++) begin
      cpu = $urandom_range(0, 1) ? cur_cpu : rand_word();
      if (cpu == cur_cpu) begin
        pick_span(off, sz);
      end else begin
        off = $urandom;
        sz = $urandom;
      end
      push(cpu, inv);
      push($urandom, inv);
      push(off, inv);
      push(sz, inv);
      for (int unsigned j = 4; j < ENTRY_WORDS; j++) begin
        push(rand_word(), inv);
      end
    end
    if ($urandom_range(0, 7) == 0 && frame_q.size() > 1) begin
      repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
    end
    repeat ($urandom_range(0, 2)) push(rand_word());
  endtask

  task automatic build_plain_frame();
    logic [31:0] sig;
    do sig = $urandom; while (sig == fbal_pkg::SIG_FAT || sig == fbal_pkg::SIG_FAT_INV ||
                              sig == fbal_pkg::SIG_EFI_FAT);
    if ($urandom_range(0, 5) == 0) sig = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
    push(sig);
    repeat ($urandom_range(0, 3)) push(rand_word());
  endtask

  task automatic build_noise_frame();
    repeat ($urandom_range(1, 6)) begin
      frame_q.push_back({($urandom_range(0, 3) == 0) ? 1'b1 : 1'b0, rand_word()});
    end
  endtask

  task automatic wait_results(bit settle);
    while (sb.pending() != 0) @(negedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_buffer();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFFF;
      5: return $urandom;
      default: return 32'd8 + 32'd20 * $urandom_range(0, 5) + $urandom_range(0, 19);
    endcase
  endfunction

  function automatic logic [31:0] pick_image();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom;
      default: return $urandom_range(2, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_cpu();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd7;
      3: return 32'h0100_0007;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb = new(ENTRY_WORDS);
    words_used = 0;
    steady = 1'b0;
    cur_buffer = 32'd0;
    cur_image = 32'd1;
    cur_cpu = 32'd7;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 32'd0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = fbal_pkg::REG_BUFFER_BYTES;
    cfg_data = 32'd0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // Short buffer straight after reset, then with seven bytes available.
    push(fbal_pkg::SIG_FAT);
    send_frame();
    wait_results(1'b1);
    write_reg(fbal_pkg::REG_BUFFER_BYTES, 32'd7);
    write_reg(fbal_pkg::REG_IMAGE_BYTES, 32'hFFFF_FFFF);
    write_reg(fbal_pkg::REG_WANTED_CPU, 32'hFFFF_FFFF);
    push(fbal_pkg::SIG_FAT_INV);
    send_frame();
    wait_results(1'b1);
    write_reg(fbal_pkg::REG_BUFFER_BYTES, 32'hFFFF_FFFF);

    // Non-fat image followed by trailing words.
    push(32'hFFFF_FFFF);
    push(32'h0000_1234);
    push(32'd0);
    send_frame();

    // Empty table, count overflow, swapped match, early end.
    push(fbal_pkg::SIG_FAT);
    push(32'd0);
    send_frame();
    push(fbal_pkg::SIG_EFI_FAT);
    push(32'h0CCC_CCCD);
    send_frame();
    push(fbal_pkg::SIG_FAT_INV);
    push(32'd1, 1'b1);
    push(32'hFFFF_FFFF, 1'b1);
    push(32'd3, 1'b1);
    push(32'h100, 1'b1);
    push(32'h200, 1'b1);
    push(32'd0, 1'b1);
    send_frame();
    push(fbal_pkg::SIG_FAT);
    push(32'd2);
    push(32'd7);
    send_frame();
    wait_results(1'b1);

    // A zero image size rejects even a zero-size slice at a nonzero offset.
    write_reg(fbal_pkg::REG_IMAGE_BYTES, 32'd0);
    write_reg(fbal_pkg::REG_WANTED_CPU, 32'd0);
    push(fbal_pkg::SIG_FAT);
    push(32'd1);
    push(32'd0);
    push(32'd0);
    push(32'h10);
    push(32'd0);
    send_frame();

    while (words_used < WORD_TARGET) begin
      wait_results(1'b1);
      steady = ($urandom_range(0, 3) == 0);
      write_reg(fbal_pkg::REG_BUFFER_BYTES, pick_buffer());
      write_reg(fbal_pkg::REG_IMAGE_BYTES, pick_image());
      write_reg(fbal_pkg::REG_WANTED_CPU, pick_cpu());
      repeat ($urandom_range(8, 20)) begin
        if (words_used >= WORD_TARGET) break;
        case ($urandom_range(0, 15))
          10, 11: build_plain_frame();
          12, 13: build_noise_frame();
          default: build_fat_frame();
        endcase
        send_frame();
        if ($urandom_range(0, 19) == 0) wait_results(1'b0);
      end
    end

    wait_results(1'b1);
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
